[rtl/bounding_box_marker_tracker_macros.svh]
// Assertion helpers for the tracker RTL, used by bmt_scan.
`ifndef BOUNDING_BOX_MARKER_TRACKER_MACROS_SVH
`define BOUNDING_BOX_MARKER_TRACKER_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define BMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed");

// Next-cycle implication, checked only while out of reset.
`define BMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed");

`endif

[rtl/bmt_pkg.sv]
`default_nettype none

package bmt_pkg;

    localparam int MARKER_SLOTS = 128;
    localparam int COORD_BITS   = 12;
    localparam int SLOT_W       = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;
    localparam int SLOT_OUT_W   = 8;
    localparam int DIM_W        = 13;
    localparam int AREA_W       = 25;
    localparam int PROD_W       = 2 * DIM_W;
    localparam int TOL_W        = 8;
    localparam int AGE_W        = TOL_W + 1;
    localparam int COUNT_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = AREA_W;

    localparam logic [AREA_W-1:0]     MIN_AREA_RST     = AREA_W'(10 * 10);
    localparam logic [AREA_W-1:0]     MAX_AREA_RST     = AREA_W'(320 * 240);
    localparam logic [TOL_W-1:0]      LOST_TOL_RST     = TOL_W'(5);
    localparam logic [COORD_BITS-1:0] MAX_MOVE_RST     = COORD_BITS'(5);
    localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RST  = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] FRAME_HEIGHT_RST = COORD_BITS'(240);

    localparam logic [SLOT_OUT_W-1:0] SLOT_NONE  = SLOT_OUT_W'(MARKER_SLOTS);
    localparam logic [SLOT_W-1:0]     SLOT_LAST  = SLOT_W'(MARKER_SLOTS - 1);
    localparam logic [COUNT_W-1:0]    COUNT_MAX  = {COUNT_W{1'b1}};

    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef enum logic [1:0] {
        OP_FRAME_START = 2'd0,
        OP_RECT        = 2'd1,
        OP_FRAME_END   = 2'd2,
        OP_CLEAR       = 2'd3
    } bmt_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_AREA     = 3'd0,
        CFG_MAX_AREA     = 3'd1,
        CFG_LOST_TOL     = 3'd2,
        CFG_MAX_MOVE     = 3'd3,
        CFG_FRAME_WIDTH  = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5
    } bmt_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILTER,
        ST_SCAN,
        ST_RESOLVE,
        ST_EMIT
    } bmt_state_t;

    typedef struct packed {
        logic [AREA_W-1:0]     min_area;
        logic [AREA_W-1:0]     max_area;
        logic [TOL_W-1:0]      lost_tolerance;
        logic [COORD_BITS-1:0] max_move;
        logic [COORD_BITS-1:0] frame_width;
        logic [COORD_BITS-1:0] frame_height;
    } bmt_cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [AGE_W-1:0] age;
        logic [COORD_BITS-1:0]   x;
        logic [COORD_BITS-1:0]   y;
    } bmt_entry_t;

    typedef struct packed {
        logic                  shift;
        logic                  age_tick;
        logic                  free_lost;
        logic                  clear_all;
        logic                  wr;
        logic [SLOT_W-1:0]     wr_slot;
        logic [COORD_BITS-1:0] wr_x;
        logic [COORD_BITS-1:0] wr_y;
        logic [TOL_W-1:0]      tol;
    } bmt_cell_cmd_t;

endpackage

`default_nettype wire

[rtl/bmt_cell.sv]
`default_nettype none

module bmt_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bmt_pkg::bmt_cell_cmd_t        cmd,
    input  wire logic [bmt_pkg::SLOT_W-1:0]    slot_id,
    input  wire bmt_pkg::bmt_entry_t           nbr,
    output bmt_pkg::bmt_entry_t                entry
);
    import bmt_pkg::*;

    logic                    valid_reg;
    logic signed [AGE_W-1:0] age_reg;
    logic [COORD_BITS-1:0]   x_reg;
    logic [COORD_BITS-1:0]   y_reg;
    logic signed [AGE_W-1:0] tol_age;
    logic                    selected;

    assign tol_age  = $signed({1'b0, cmd.tol});
    assign selected = cmd.wr && (cmd.wr_slot == slot_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= $signed({1'b0, LOST_TOL_RST});
        end
        else if (cmd.clear_all)
        begin
            valid_reg <= 1'b0;
            age_reg   <= tol_age;
        end
        else if (cmd.shift)
        begin
            valid_reg <= nbr.valid;
            age_reg   <= nbr.age;
        end
        else if (cmd.age_tick)
        begin
            // Ages stop at minus one so that a marker is freed exactly once.
            if (valid_reg && (age_reg >= 0))
            begin
                age_reg <= age_reg - AGE_W'(1);
            end
        end
        else if (cmd.free_lost)
        begin
            if (age_reg < 0)
            begin
                valid_reg <= 1'b0;
                age_reg   <= tol_age;
            end
        end
        else if (selected)
        begin
            valid_reg <= 1'b1;
            age_reg   <= tol_age;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            x_reg <= nbr.x;
            y_reg <= nbr.y;
        end
        else if (selected && !cmd.clear_all)
        begin
            x_reg <= cmd.wr_x;
            y_reg <= cmd.wr_y;
        end
    end

    always_comb
    begin
        entry.valid = valid_reg;
        entry.age   = age_reg;
        entry.x     = x_reg;
        entry.y     = y_reg;
    end

endmodule

`default_nettype wire

[rtl/bmt_scan.sv]
`default_nettype none

`include "bounding_box_marker_tracker_macros.svh"

module bmt_scan (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bmt_pkg::bmt_cfg_t                 cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        opcode,
    input  wire logic [bmt_pkg::COORD_BITS-1:0]    rect_x,
    input  wire logic [bmt_pkg::COORD_BITS-1:0]    rect_y,
    input  wire logic [bmt_pkg::DIM_W-1:0]         rect_w,
    input  wire logic [bmt_pkg::DIM_W-1:0]         rect_h,
    input  wire bmt_pkg::bmt_entry_t               head,
    output bmt_pkg::bmt_cell_cmd_t                 cmd,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   kind,
    output logic [bmt_pkg::COUNT_W-1:0]            report_index,
    output logic [bmt_pkg::COORD_BITS-1:0]         out_x,
    output logic [bmt_pkg::COORD_BITS-1:0]         out_y,
    output logic [bmt_pkg::DIM_W-1:0]              out_w,
    output logic [bmt_pkg::DIM_W-1:0]              out_h,
    output logic [bmt_pkg::SLOT_OUT_W-1:0]         marker_slot,
    output logic                                   new_marker,
    output logic [bmt_pkg::COUNT_W-1:0]            object_count
);
    import bmt_pkg::*;

    bmt_state_t              state_reg, state_next;
    bmt_op_t                 op_reg;
    logic [COORD_BITS-1:0]   rx_reg, ry_reg;
    logic [DIM_W-1:0]        rw_reg, rh_reg;
    logic [PROD_W-1:0]       area_reg;
    logic [SLOT_W-1:0]       idx_reg;
    logic                    match_found_reg, free_found_reg;
    logic [SLOT_W-1:0]       match_idx_reg, free_idx_reg;
    logic [SLOT_OUT_W-1:0]   slot_reg;
    logic                    fresh_reg;
    logic [COUNT_W-1:0]      count_reg;

    logic                    out_valid_reg;
    logic                    kind_reg;
    logic [COUNT_W-1:0]      index_reg;
    logic [COORD_BITS-1:0]   ox_reg, oy_reg;
    logic [DIM_W-1:0]        ow_reg, oh_reg;
    logic [SLOT_OUT_W-1:0]   oslot_reg;
    logic                    onew_reg;
    logic [COUNT_W-1:0]      ocount_reg;

    logic                    accept;
    logic                    area_ok;
    logic                    in_frame;
    logic [COORD_BITS-1:0]   dx, dy;
    logic                    match_hit;
    logic                    free_hit;
    logic                    out_free;
    logic                    claim;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign area_ok  = (area_reg > PROD_W'(cfg.min_area)) && (area_reg < PROD_W'(cfg.max_area));
    assign in_frame = (rx_reg <= cfg.frame_width) && (ry_reg <= cfg.frame_height);
    assign dx       = (rx_reg >= head.x) ? (rx_reg - head.x) : (head.x - rx_reg);
    assign dy       = (ry_reg >= head.y) ? (ry_reg - head.y) : (head.y - ry_reg);
    assign match_hit = head.valid && (dx < cfg.max_move) && (dy < cfg.max_move);
    assign free_hit  = !head.valid;
    assign claim     = !match_found_reg && in_frame && free_found_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_RECT:      state_next = ST_FILTER;
                    OP_FRAME_END: state_next = ST_EMIT;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_FILTER:
            begin
                state_next = area_ok ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (idx_reg == SLOT_LAST)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: handshake and commands to the cells.
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.shift     = 1'b0;
        cmd.age_tick  = 1'b0;
        cmd.free_lost = 1'b0;
        cmd.clear_all = 1'b0;
        cmd.wr        = 1'b0;
        cmd.wr_slot   = match_found_reg ? match_idx_reg : free_idx_reg;
        cmd.wr_x      = rx_reg;
        cmd.wr_y      = ry_reg;
        cmd.tol       = cfg.lost_tolerance;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.age_tick  = (op_reg == OP_FRAME_START);
                cmd.free_lost = (op_reg == OP_FRAME_END);
                cmd.clear_all = (op_reg == OP_CLEAR);
            end
            ST_SCAN:
            begin
                cmd.shift = 1'b1;
            end
            ST_RESOLVE:
            begin
                cmd.wr = match_found_reg || claim;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Transaction fields and the scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= bmt_op_t'(opcode);
            rx_reg <= rect_x;
            ry_reg <= rect_y;
            rw_reg <= rect_w;
            rh_reg <= rect_h;
        end
        if (state_reg == ST_EXEC)
        begin
            area_reg <= PROD_W'(rw_reg) * PROD_W'(rh_reg);
        end
        if (state_reg == ST_FILTER)
        begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            // The chain rotates by one slot per cycle, so the head holds slot idx_reg.
            idx_reg <= idx_reg + SLOT_W'(1);
            if (match_hit && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= idx_reg;
            end
            if (free_hit && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
        end
        if (state_reg == ST_RESOLVE)
        begin
            if (match_found_reg)
            begin
                slot_reg  <= SLOT_OUT_W'(match_idx_reg);
                fresh_reg <= 1'b0;
            end
            else if (claim)
            begin
                slot_reg  <= SLOT_OUT_W'(free_idx_reg);
                fresh_reg <= 1'b1;
            end
            else
            begin
                slot_reg  <= SLOT_NONE;
                fresh_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if ((state_reg == ST_EXEC) && (op_reg == OP_FRAME_START))
        begin
            count_reg <= '0;
        end
        else if ((state_reg == ST_EMIT) && out_free && (op_reg == OP_RECT) &&
                 (count_reg != COUNT_MAX))
        begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EMIT) && out_free)
        begin
            if (op_reg == OP_RECT)
            begin
                kind_reg   <= KIND_BOX;
                index_reg  <= count_reg;
                ox_reg     <= rx_reg;
                oy_reg     <= ry_reg;
                ow_reg     <= rw_reg;
                oh_reg     <= rh_reg;
                oslot_reg  <= slot_reg;
                onew_reg   <= fresh_reg;
                ocount_reg <= '0;
            end
            else
            begin
                kind_reg   <= KIND_TOTAL;
                index_reg  <= '0;
                ox_reg     <= '0;
                oy_reg     <= '0;
                ow_reg     <= '0;
                oh_reg     <= '0;
                oslot_reg  <= '0;
                onew_reg   <= 1'b0;
                ocount_reg <= count_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign report_index = index_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_w        = ow_reg;
    assign out_h        = oh_reg;
    assign marker_slot  = oslot_reg;
    assign new_marker   = onew_reg;
    assign object_count = ocount_reg;

    `BMT_ASSERT_NOW(a_full_rotation, clk, rst_n, state_reg == ST_RESOLVE,
        $past(state_reg) == ST_SCAN && $past(idx_reg) == SLOT_LAST)
    `BMT_ASSERT_NEXT(a_frame_start_clears, clk, rst_n,
        state_reg == ST_EXEC && op_reg == OP_FRAME_START, count_reg == '0)
    `BMT_ASSERT_NOW(a_load_from_emit, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == ST_EMIT)
    `BMT_ASSERT_NOW(a_new_has_slot, clk, rst_n, out_valid_reg && onew_reg,
        kind_reg == KIND_BOX && oslot_reg != SLOT_NONE)

endmodule

`default_nettype wire

[rtl/bounding_box_marker_tracker.sv]
// Tracks up to 128 markers from a stream of bounding-box transactions: frame start,
// rectangle, frame end and clear. The marker table is a ring of cells that rotates
// by one slot per clock while a rectangle is scanned, and a rectangle is compared
// against the slot at the head of the ring. A rectangle that passes the area filter
// goes through decode with area, filter, one full rotation of the ring, slot resolve
// and output before its report is loaded; one that fails the filter is dropped after
// the filter step. Frame start and clear act on all cells at once,
// and frame end returns the frame total. A new transaction is taken once the
// previous one is done, even while a report still waits in the output register.
// Configuration must only be written while the block is idle.
`default_nettype none

module bounding_box_marker_tracker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wen,
    input  wire logic [bmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bmt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        opcode,
    input  wire logic [bmt_pkg::COORD_BITS-1:0]    rect_x,
    input  wire logic [bmt_pkg::COORD_BITS-1:0]    rect_y,
    input  wire logic [bmt_pkg::DIM_W-1:0]         rect_w,
    input  wire logic [bmt_pkg::DIM_W-1:0]         rect_h,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   kind,
    output logic [bmt_pkg::COUNT_W-1:0]            report_index,
    output logic [bmt_pkg::COORD_BITS-1:0]         out_x,
    output logic [bmt_pkg::COORD_BITS-1:0]         out_y,
    output logic [bmt_pkg::DIM_W-1:0]              out_w,
    output logic [bmt_pkg::DIM_W-1:0]              out_h,
    output logic [bmt_pkg::SLOT_OUT_W-1:0]         marker_slot,
    output logic                                   new_marker,
    output logic [bmt_pkg::COUNT_W-1:0]            object_count
);
    import bmt_pkg::*;

    bmt_cfg_t      cfg_reg;
    bmt_cell_cmd_t cmd;
    bmt_entry_t    entries [MARKER_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_area       <= MIN_AREA_RST;
            cfg_reg.max_area       <= MAX_AREA_RST;
            cfg_reg.lost_tolerance <= LOST_TOL_RST;
            cfg_reg.max_move       <= MAX_MOVE_RST;
            cfg_reg.frame_width    <= FRAME_WIDTH_RST;
            cfg_reg.frame_height   <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_MIN_AREA:     cfg_reg.min_area       <= cfg_wdata[AREA_W-1:0];
                CFG_MAX_AREA:     cfg_reg.max_area       <= cfg_wdata[AREA_W-1:0];
                CFG_LOST_TOL:     cfg_reg.lost_tolerance <= cfg_wdata[TOL_W-1:0];
                CFG_MAX_MOVE:     cfg_reg.max_move       <= cfg_wdata[COORD_BITS-1:0];
                CFG_FRAME_WIDTH:  cfg_reg.frame_width    <= cfg_wdata[COORD_BITS-1:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height   <= cfg_wdata[COORD_BITS-1:0];
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Each cell takes the contents of its upper neighbor, closing the ring at the top.
    for (genvar i = 0; i < MARKER_SLOTS; i++)
    begin : g_cell
        bmt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .slot_id (SLOT_W'(i)),
            .nbr     (entries[(i + 1) % MARKER_SLOTS]),
            .entry   (entries[i])
        );
    end

    bmt_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_w       (rect_w),
        .rect_h       (rect_h),
        .head         (entries[0]),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .report_index (report_index),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_w        (out_w),
        .out_h        (out_h),
        .marker_slot  (marker_slot),
        .new_marker   (new_marker),
        .object_count (object_count)
    );

endmodule

`default_nettype wire

[tb/sv/bounding_box_marker_tracker_test.sv]
`timescale 1ns / 1ps

module bounding_box_marker_tracker_test;

    import bmt_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_LEN   = 150;
    localparam int MAX_OBJECTS  = 16;

    typedef struct packed {
        logic                  kind;
        logic [COUNT_W-1:0]    report_index;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  new_marker;
        logic [COUNT_W-1:0]    count;
    } tracker_report_t;

    typedef struct {
        bmt_op_t               op;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
        bit                    typed;
        tracker_report_t       want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wen;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              opcode;
    logic [COORD_BITS-1:0]   rect_x;
    logic [COORD_BITS-1:0]   rect_y;
    logic [DIM_W-1:0]        rect_w;
    logic [DIM_W-1:0]        rect_h;
    logic                    out_valid;
    logic                    out_ready;
    logic                    kind;
    logic [COUNT_W-1:0]      report_index;
    logic [COORD_BITS-1:0]   out_x;
    logic [COORD_BITS-1:0]   out_y;
    logic [DIM_W-1:0]        out_w;
    logic [DIM_W-1:0]        out_h;
    logic [SLOT_OUT_W-1:0]   marker_slot;
    logic                    new_marker;
    logic [COUNT_W-1:0]      object_count;

    // Shadow of the marker table and the registers.
    bmt_cfg_t                tracker_cfg;
    logic [COORD_BITS-1:0]   mk_x [MARKER_SLOTS];
    logic [COORD_BITS-1:0]   mk_y [MARKER_SLOTS];
    logic signed [AGE_W-1:0] mk_age [MARKER_SLOTS];
    logic                    mk_valid [MARKER_SLOTS];
    logic [COUNT_W-1:0]      boxes_in_frame;

    tracker_report_t         pending_reports [$];
    stim_row_t               directed_rows [$];

    // Objects that the stimulus moves around so that boxes land near markers.
    logic [COORD_BITS-1:0]   obj_x [MAX_OBJECTS];
    logic [COORD_BITS-1:0]   obj_y [MAX_OBJECTS];
    int                      obj_count;

    int                      burst_left;
    int                      items_sent;
    int                      mismatches;
    int                      quiet_cycles;

    bounding_box_marker_tracker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_w       (rect_w),
        .rect_h       (rect_h),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .report_index (report_index),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_w        (out_w),
        .out_h        (out_h),
        .marker_slot  (marker_slot),
        .new_marker   (new_marker),
        .object_count (object_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void wipe_table();
        for (int i = 0; i < MARKER_SLOTS; i++)
        begin
            mk_valid[i] = 1'b0;
            mk_age[i]   = AGE_W'(tracker_cfg.lost_tolerance);
        end
    endfunction

    function automatic bit predict_item(input bmt_op_t op,
                                        input logic [COORD_BITS-1:0] x,
                                        input logic [COORD_BITS-1:0] y,
                                        input logic [DIM_W-1:0] w,
                                        input logic [DIM_W-1:0] h,
                                        output tracker_report_t rpt);
        logic [PROD_W-1:0] area;
        int                hit;
        bit                fresh;
        int                dx;
        int                dy;
        rpt = '0;
        case (op)
            OP_FRAME_START:
            begin
                boxes_in_frame = '0;
                for (int i = 0; i < MARKER_SLOTS; i++)
                    if (mk_valid[i] && mk_age[i] > -1)
                        mk_age[i] = mk_age[i] - 1;
                return 1'b0;
            end
            OP_CLEAR:
            begin
                wipe_table();
                return 1'b0;
            end
            OP_FRAME_END:
            begin
                rpt.kind  = KIND_TOTAL;
                rpt.count = boxes_in_frame;
                for (int i = 0; i < MARKER_SLOTS; i++)
                    if (mk_age[i] < 0)
                    begin
                        mk_valid[i] = 1'b0;
                        mk_age[i]   = AGE_W'(tracker_cfg.lost_tolerance);
                    end
                return 1'b1;
            end
            default:
            begin
                area = PROD_W'(w) * PROD_W'(h);
                if (!(area > tracker_cfg.min_area && area < tracker_cfg.max_area))
                    return 1'b0;
                hit   = -1;
                fresh = 1'b0;
                for (int i = 0; i < MARKER_SLOTS; i++)
                    if (hit < 0 && mk_valid[i])
                    begin
                        dx = (x >= mk_x[i]) ? int'(x) - int'(mk_x[i]) : int'(mk_x[i]) - int'(x);
                        dy = (y >= mk_y[i]) ? int'(y) - int'(mk_y[i]) : int'(mk_y[i]) - int'(y);
                        if (dx < int'(tracker_cfg.max_move) && dy < int'(tracker_cfg.max_move))
                            hit = i;
                    end
                if (hit < 0 && x <= tracker_cfg.frame_width && y <= tracker_cfg.frame_height)
                    for (int i = 0; i < MARKER_SLOTS; i++)
                        if (hit < 0 && !mk_valid[i])
                        begin
                            hit   = i;
                            fresh = 1'b1;
                        end
                if (hit >= 0)
                begin
                    mk_valid[hit] = 1'b1;
                    mk_x[hit]     = x;
                    mk_y[hit]     = y;
                    mk_age[hit]   = AGE_W'(tracker_cfg.lost_tolerance);
                end
                rpt.kind         = KIND_BOX;
                rpt.report_index = boxes_in_frame;
                rpt.x            = x;
                rpt.y            = y;
                rpt.w            = w;
                rpt.h            = h;
                rpt.slot         = (hit >= 0) ? SLOT_OUT_W'(hit) : SLOT_NONE;
                rpt.new_marker   = fresh;
                if (boxes_in_frame != COUNT_MAX)
                    boxes_in_frame = boxes_in_frame + 1'b1;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic tracker_report_t box_rpt(input int idx, input int x, input int y,
                                                input int w, input int h,
                                                input int slot, input bit fresh);
        tracker_report_t r;
        r              = '0;
        r.kind         = KIND_BOX;
        r.report_index = COUNT_W'(idx);
        r.x            = COORD_BITS'(x);
        r.y            = COORD_BITS'(y);
        r.w            = DIM_W'(w);
        r.h            = DIM_W'(h);
        r.slot         = SLOT_OUT_W'(slot);
        r.new_marker   = fresh;
        return r;
    endfunction

    function automatic tracker_report_t total_rpt(input int count);
        tracker_report_t r;
        r       = '0;
        r.kind  = KIND_TOTAL;
        r.count = COUNT_W'(count);
        return r;
    endfunction

    function automatic void put_row(input bmt_op_t op, input int x, input int y,
                                    input int w, input int h,
                                    input bit typed, input tracker_report_t want);
        stim_row_t row;
        row.op    = op;
        row.x     = COORD_BITS'(x);
        row.y     = COORD_BITS'(y);
        row.w     = DIM_W'(w);
        row.h     = DIM_W'(h);
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Called and returns at a falling edge. Bursts of transactions are separated by
    // random gaps; now and then the sender holds off until every report is back.
    task automatic send_item(input bmt_op_t op,
                             input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y,
                             input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h,
                             input bit typed, input tracker_report_t want);
        tracker_report_t rpt;
        bit              has;
        int              gap;
        if ($urandom_range(0, 49) == 0)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (pending_reports.size() != 0)
                @(negedge clk);
        end
        else if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rect_x   <= x;
        rect_y   <= y;
        rect_w   <= w;
        rect_h   <= h;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        has = predict_item(op, x, y, w, h, rpt);
        if (typed)
            pending_reports.push_back(want);
        else if (has)
            pending_reports.push_back(rpt);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    // Let the block drain and finish any transaction that produces no report.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_LEN) @(negedge clk);
    endtask

    task automatic put_reg(input bmt_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [AREA_W-1:0] min_a,
                                  input logic [AREA_W-1:0] max_a,
                                  input logic [TOL_W-1:0] tol,
                                  input logic [COORD_BITS-1:0] move,
                                  input logic [COORD_BITS-1:0] fw,
                                  input logic [COORD_BITS-1:0] fh);
        put_reg(CFG_MIN_AREA, CFG_DATA_W'(min_a));
        put_reg(CFG_MAX_AREA, CFG_DATA_W'(max_a));
        put_reg(CFG_LOST_TOL, CFG_DATA_W'(tol));
        put_reg(CFG_MAX_MOVE, CFG_DATA_W'(move));
        put_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(fw));
        put_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(fh));
        cfg_wen <= 1'b0;
        tracker_cfg.min_area       = min_a;
        tracker_cfg.max_area       = max_a;
        tracker_cfg.lost_tolerance = tol;
        tracker_cfg.max_move       = move;
        tracker_cfg.frame_width    = fw;
        tracker_cfg.frame_height   = fh;
    endtask

    task automatic pick_dims(input bit fit, output logic [DIM_W-1:0] w,
                             output logic [DIM_W-1:0] h);
        logic [PROD_W-1:0] area;
        if (!fit)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    w = '0;
                    h = DIM_W'($urandom_range(0, 4096));
                end
                1:
                begin
                    w = DIM_W'(4096);
                    h = DIM_W'(4096);
                end
                2:
                begin
                    w = DIM_W'($urandom_range(0, 4096));
                    h = '0;
                end
                default:
                begin
                    w = DIM_W'($urandom_range(0, 4096));
                    h = DIM_W'($urandom_range(0, 4096));
                end
            endcase
        end
        else
        begin
            // Log-uniform sides, retried up to 24 times until the area lands inside the window.
            for (int t = 0; t < 24; t++)
            begin
                w    = DIM_W'($urandom_range(1, 4096 >> $urandom_range(0, 12)));
                h    = DIM_W'($urandom_range(1, 4096 >> $urandom_range(0, 12)));
                area = PROD_W'(w) * PROD_W'(h);
                if (area > tracker_cfg.min_area && area < tracker_cfg.max_area)
                    break;
            end
        end
    endtask

    // One frame: start, a few boxes mostly near tracked objects, end. Some frames
    // lose their start or end, and some items are plain noise.
    task automatic random_frame();
        int                    nrect;
        int                    p;
        int                    k;
        int                    j;
        int                    nx;
        int                    ny;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
        nrect = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 10);
        if ($urandom_range(0, 99) < 92)
            send_item(OP_FRAME_START, '0, '0, '0, '0, 1'b0, '0);
        for (int n = 0; n < nrect; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 8)
            begin
                send_item(bmt_op_t'($urandom_range(0, 3)), COORD_BITS'($urandom),
                          COORD_BITS'($urandom), DIM_W'($urandom_range(0, 4096)),
                          DIM_W'($urandom_range(0, 4096)), 1'b0, '0);
            end
            else if (p < 11)
            begin
                send_item(OP_CLEAR, '0, '0, '0, '0, 1'b0, '0);
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (obj_count > 0 && p < 65)
                begin
                    // Jitter of up to max_move (capped at 64) lands on both sides of the match bound.
                    k  = $urandom_range(0, obj_count - 1);
                    j  = (tracker_cfg.max_move > 64) ? 64 : int'(tracker_cfg.max_move);
                    nx = int'(obj_x[k]) + int'($urandom_range(0, 2 * j)) - j;
                    ny = int'(obj_y[k]) + int'($urandom_range(0, 2 * j)) - j;
                    nx = (nx < 0) ? 0 : ((nx > 4095) ? 4095 : nx);
                    ny = (ny < 0) ? 0 : ((ny > 4095) ? 4095 : ny);
                    obj_x[k] = COORD_BITS'(nx);
                    obj_y[k] = COORD_BITS'(ny);
                    x = obj_x[k];
                    y = obj_y[k];
                end
                else if (p < 88)
                begin
                    x = COORD_BITS'($urandom_range(0, tracker_cfg.frame_width));
                    y = COORD_BITS'($urandom_range(0, tracker_cfg.frame_height));
                    k = (obj_count < MAX_OBJECTS) ? obj_count
                                                  : $urandom_range(0, MAX_OBJECTS - 1);
                    obj_x[k] = x;
                    obj_y[k] = y;
                    if (obj_count < MAX_OBJECTS)
                        obj_count++;
                end
                else
                begin
                    x = COORD_BITS'($urandom);
                    y = COORD_BITS'($urandom);
                end
                pick_dims($urandom_range(0, 99) < 85, w, h);
                send_item(OP_RECT, x, y, w, h, 1'b0, '0);
            end
        end
        if ($urandom_range(0, 99) < 92)
            send_item(OP_FRAME_END, '0, '0, '0, '0, 1'b0, '0);
    endtask

    task automatic run_phase(input int budget);
        int stop_at;
        stop_at   = items_sent + budget;
        obj_count = 0;
        while (items_sent < stop_at)
            random_frame();
    endtask

    // Receiver: switches between always ready, coin flips, a fixed duty cycle
    // and long stalls.
    initial
    begin : rx_pattern
        int mode;
        int mode_left;
        int tick;
        out_ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            tick++;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= (tick % 4 == 0);
                default: out_ready <= ($urandom_range(0, 31) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : report_check
        tracker_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with nothing outstanding: kind %0d index %0d",
                       kind, report_index);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("kind", want.kind, kind);
                check_field("report_index", want.report_index, report_index);
                check_field("out_x", want.x, out_x);
                check_field("out_y", want.y, out_y);
                check_field("out_w", want.w, out_w);
                check_field("out_h", want.h, out_h);
                check_field("marker_slot", want.slot, marker_slot);
                check_field("new_marker", want.new_marker, new_marker);
                check_field("object_count", want.count, object_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [AREA_W-1:0] lo;
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        opcode       = '0;
        rect_x       = '0;
        rect_y       = '0;
        rect_w       = '0;
        rect_h       = '0;
        burst_left   = 0;
        items_sent   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        obj_count    = 0;

        tracker_cfg.min_area       = MIN_AREA_RST;
        tracker_cfg.max_area       = MAX_AREA_RST;
        tracker_cfg.lost_tolerance = LOST_TOL_RST;
        tracker_cfg.max_move       = MAX_MOVE_RST;
        tracker_cfg.frame_width    = FRAME_WIDTH_RST;
        tracker_cfg.frame_height   = FRAME_HEIGHT_RST;
        for (int i = 0; i < MARKER_SLOTS; i++)
        begin
            mk_x[i] = '0;
            mk_y[i] = '0;
        end
        wipe_table();
        boxes_in_frame = '0;

        // Directed rows run under the reset register values.
        put_row(OP_FRAME_END, 0, 0, 0, 0, 1'b1, total_rpt(0));
        put_row(OP_FRAME_START, 0, 0, 0, 0, 1'b0, '0);
        put_row(OP_RECT, 0, 0, 11, 10, 1'b1, box_rpt(0, 0, 0, 11, 10, 0, 1'b1));
        put_row(OP_RECT, 50, 50, 10, 10, 1'b0, '0);
        put_row(OP_RECT, 50, 50, 320, 240, 1'b0, '0);
        put_row(OP_RECT, 100, 100, 319, 240, 1'b1, box_rpt(1, 100, 100, 319, 240, 1, 1'b1));
        put_row(OP_RECT, 4, 4, 12, 12, 1'b1, box_rpt(2, 4, 4, 12, 12, 0, 1'b0));
        // A distance equal to max_move does not match.
        put_row(OP_RECT, 9, 4, 12, 12, 1'b1, box_rpt(3, 9, 4, 12, 12, 2, 1'b1));
        put_row(OP_RECT, 321, 10, 12, 12, 1'b1, box_rpt(4, 321, 10, 12, 12, SLOT_NONE, 1'b0));
        put_row(OP_RECT, 320, 240, 12, 12, 1'b1, box_rpt(5, 320, 240, 12, 12, 3, 1'b1));
        put_row(OP_RECT, 10, 241, 12, 12, 1'b1, box_rpt(6, 10, 241, 12, 12, SLOT_NONE, 1'b0));
        put_row(OP_RECT, 4095, 4095, 4096, 4096, 1'b0, '0);
        put_row(OP_RECT, 2000, 2000, 0, 4096, 1'b0, '0);
        put_row(OP_FRAME_END, 0, 0, 0, 0, 1'b1, total_rpt(7));
        put_row(OP_FRAME_START, 0, 0, 0, 0, 1'b0, '0);
        put_row(OP_RECT, 4095, 0, 4096, 1, 1'b1, box_rpt(0, 4095, 0, 4096, 1, SLOT_NONE, 1'b0));
        // Clear empties the table but keeps the running index.
        put_row(OP_CLEAR, 0, 0, 0, 0, 1'b0, '0);
        put_row(OP_RECT, 4, 4, 20, 20, 1'b1, box_rpt(1, 4, 4, 20, 20, 0, 1'b1));
        put_row(OP_FRAME_END, 0, 0, 0, 0, 1'b1, total_rpt(2));
        // Seven unseen frames push the age past zero, where it stays at minus one.
        for (int i = 0; i < 7; i++)
            put_row(OP_FRAME_START, 0, 0, 0, 0, 1'b0, '0);
        put_row(OP_FRAME_END, 0, 0, 0, 0, 1'b1, total_rpt(0));
        put_row(OP_RECT, 4, 4, 20, 20, 1'b1, box_rpt(0, 4, 4, 20, 20, 0, 1'b1));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].w, directed_rows[i].h,
                      directed_rows[i].typed, directed_rows[i].want);

        settle();
        apply_settings(25'd100, 25'd76800, 8'd3, 12'd8, 12'd320, 12'd240);
        run_phase(110);

        settle();
        apply_settings(25'd0, 25'h1000000, 8'd255, 12'd4095, 12'd4095, 12'd4095);
        run_phase(90);

        // With zero tolerance and zero move distance nothing ever matches, so one
        // long frame claims every slot and the last boxes find the table full.
        settle();
        apply_settings(25'd0, 25'h1000000, 8'd0, 12'd0, 12'd4095, 12'd4095);
        send_item(OP_FRAME_START, '0, '0, '0, '0, 1'b0, '0);
        for (int n = 0; n < MARKER_SLOTS + 4; n++)
        begin
            pick_dims(1'b1, w, h);
            send_item(OP_RECT, COORD_BITS'($urandom), COORD_BITS'($urandom), w, h, 1'b0, '0);
        end
        send_item(OP_FRAME_END, '0, '0, '0, '0, 1'b0, '0);
        run_phase(60);

        settle();
        apply_settings(25'd1, 25'd10, 8'd1, 12'd1, 12'd1, 12'd1);
        run_phase(70);

        for (int r = 0; r < 2; r++)
        begin
            settle();
            lo = AREA_W'($urandom_range(0, 3000));
            apply_settings(lo, lo + AREA_W'($urandom_range(2, 300000)),
                           TOL_W'($urandom_range(0, 255)),
                           COORD_BITS'($urandom_range(1, 40)),
                           COORD_BITS'($urandom_range(1, 4095)),
                           COORD_BITS'($urandom_range(1, 4095)));
            run_phase(45);
        end

        settle();
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bmt_pkg.sv
rtl/bmt_cell.sv
rtl/bmt_scan.sv
rtl/bounding_box_marker_tracker.sv
tb/sv/bounding_box_marker_tracker_test.sv
